[rtl/sigma_threshold_pretrigger_capture_macros.svh]
// assertion macros shared by the capture block
`ifndef SIGMA_THRESHOLD_PRETRIGGER_CAPTURE_MACROS_SVH
`define SIGMA_THRESHOLD_PRETRIGGER_CAPTURE_MACROS_SVH

// same-cycle implication, checked out of reset
`define STPC_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("capture block check failed");

// next-cycle implication, checked out of reset
`define STPC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("capture block check failed");

`endif

[rtl/stpc_pkg.sv]
// shared types and constants of the pretrigger capture block
package stpc_pkg;

    localparam int NUM_CH     = 4;
    localparam int SAMPLE_W   = 16;
    localparam int FRAME_W    = NUM_CH * SAMPLE_W;
    localparam int SIGMA_W    = 8;
    localparam int PREF_W     = 7;
    localparam int POSTF_W    = 11;
    localparam int PROD_W     = SIGMA_W + SAMPLE_W;
    localparam int THR_W      = PROD_W + 2;
    localparam int COUNT_W    = 32;
    localparam int APB_DATA_W = 64;
    localparam int APB_ADDR_W = 6;

    localparam logic [SIGMA_W-1:0] SIGMA_RST = 8'd3;
    localparam logic [PREF_W-1:0]  PRE_RST   = 7'd8;
    localparam logic [POSTF_W-1:0] POST_RST  = 11'd16;

    typedef logic [FRAME_W-1:0] frame_t;

    // register map, one 64-bit slot per register
    typedef enum logic [2:0] {
        REG_SIGMA = 3'd0,
        REG_PRE   = 3'd1,
        REG_POST  = 3'd2,
        REG_MEAN  = 3'd3,
        REG_RMS   = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic [SIGMA_W-1:0] sigma;
        logic [PREF_W-1:0]  pre_frames;
        logic [POSTF_W-1:0] post_frames;
        logic [FRAME_W-1:0] mean_packed;
        logic [FRAME_W-1:0] rms_packed;
    } cfg_t;

endpackage

[rtl/stpc_regs.sv]
// configuration register file behind the apb port
module stpc_regs
    import stpc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[APB_ADDR_W-1:3]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    // register writes on the access phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sigma       <= SIGMA_RST;
            cfg_reg.pre_frames  <= PRE_RST;
            cfg_reg.post_frames <= POST_RST;
            cfg_reg.mean_packed <= '0;
            cfg_reg.rms_packed  <= '0;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_SIGMA: cfg_reg.sigma       <= pwdata[SIGMA_W-1:0];
                REG_PRE:   cfg_reg.pre_frames  <= pwdata[PREF_W-1:0];
                REG_POST:  cfg_reg.post_frames <= pwdata[POSTF_W-1:0];
                REG_MEAN:  cfg_reg.mean_packed <= pwdata[FRAME_W-1:0];
                REG_RMS:   cfg_reg.rms_packed  <= pwdata[FRAME_W-1:0];
                default:   ;
            endcase
        end
    end

    // read mux
    always_comb
    begin
        case (idx)
            REG_SIGMA: prdata = APB_DATA_W'(cfg_reg.sigma);
            REG_PRE:   prdata = APB_DATA_W'(cfg_reg.pre_frames);
            REG_POST:  prdata = APB_DATA_W'(cfg_reg.post_frames);
            REG_MEAN:  prdata = APB_DATA_W'(cfg_reg.mean_packed);
            REG_RMS:   prdata = APB_DATA_W'(cfg_reg.rms_packed);
            default:   prdata = '0;
        endcase
    end

endmodule

[rtl/stpc_detect.sv]
// per-channel excess threshold compare for one frame
module stpc_detect
    import stpc_pkg::*;
(
    input  cfg_t   cfg,
    input  frame_t frame,
    output logic   hit
);

    logic        [PROD_W-1:0] dev   [NUM_CH];
    logic signed [THR_W-1:0]  mean  [NUM_CH];
    logic signed [THR_W-1:0]  samp  [NUM_CH];
    logic signed [THR_W-1:0]  upper [NUM_CH];
    logic signed [THR_W-1:0]  lower [NUM_CH];
    logic        [NUM_CH-1:0] ch_hit;

    // mean +/- sigma*rms, exact in THR_W bits, one lane per channel
    always_comb
    begin
        for (int c = 0; c < NUM_CH; c++)
        begin
            dev[c]   = PROD_W'(cfg.sigma) *
                       PROD_W'(cfg.rms_packed[c*SAMPLE_W +: SAMPLE_W]);
            mean[c]  = THR_W'(signed'(cfg.mean_packed[c*SAMPLE_W +: SAMPLE_W]));
            samp[c]  = THR_W'(signed'(frame[c*SAMPLE_W +: SAMPLE_W]));
            upper[c] = mean[c] + signed'({2'b00, dev[c]});
            lower[c] = mean[c] - signed'({2'b00, dev[c]});
            ch_hit[c] = (samp[c] >= upper[c]) || (samp[c] <= lower[c]);
        end
    end

    assign hit = |ch_hit;

endmodule

[rtl/stpc_history.sv]
// pretrigger delay line: one write port, one registered read port
module stpc_history
    import stpc_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int AW    = 6
)
(
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  frame_t        wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output frame_t        rd_data
);

    frame_t mem [DEPTH];
    frame_t rd_data_reg;

    // read returns the old contents when both ports hit the same entry
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/sigma_threshold_pretrigger_capture.sv]
// Pretrigger threshold capture over four-channel frames. One frame is taken
// per clock and a window frame leaves per clock while out_ready is high; a
// beat passes through the input register, then the result register, whose
// samples come from the delay-line read register when the window reaches
// back. in_ready follows out_ready combinationally when both stages are
// full. A frame triggers when any channel lies at or beyond mean +/-
// sigma*rms; the window then runs from pre_frames before the trigger through
// post_frames - 1 after it, replayed from a PRE_DEPTH-entry delay line at the
// rate frames arrive. Registers sit at byte addresses 8*i on the APB port.
module sigma_threshold_pretrigger_capture
    import stpc_pkg::*;
#(
    parameter int PRE_DEPTH = 64,
    parameter int POST_MAX  = 1024
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [APB_ADDR_W-1:0]      paddr,
    input  logic [APB_DATA_W-1:0]      pwdata,
    output logic [APB_DATA_W-1:0]      prdata,
    output logic                       pready,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic signed [SAMPLE_W-1:0] sample_ch0,
    input  logic signed [SAMPLE_W-1:0] sample_ch1,
    input  logic signed [SAMPLE_W-1:0] sample_ch2,
    input  logic signed [SAMPLE_W-1:0] sample_ch3,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [SAMPLE_W-1:0] out_ch0,
    output logic signed [SAMPLE_W-1:0] out_ch1,
    output logic signed [SAMPLE_W-1:0] out_ch2,
    output logic signed [SAMPLE_W-1:0] out_ch3,
    output logic [COUNT_W-1:0]         window_start,
    output logic                       is_last
);

`include "sigma_threshold_pretrigger_capture_macros.svh"

    localparam int AW  = (PRE_DEPTH > 1) ? $clog2(PRE_DEPTH) : 1;
    localparam int PCW = $clog2(PRE_DEPTH + 1);
    localparam int PSW = $clog2(POST_MAX + 1);
    localparam int FLW = $clog2(PRE_DEPTH + POST_MAX + 1);

    cfg_t cfg;

    // pipeline registers
    logic               s1_valid_reg, s1_valid_next;
    frame_t             s1_frame_reg;
    logic               out_valid_reg, out_valid_next;
    logic               out_from_mem_reg;
    frame_t             out_frame_reg;
    logic [COUNT_W-1:0] out_start_reg;
    logic               out_last_reg;

    // capture state
    logic [COUNT_W-1:0] frame_count_reg, frame_count_next;
    logic [AW-1:0]      hist_wr_reg, hist_wr_next;
    logic [PCW-1:0]     primed_reg, primed_next;
    logic [FLW-1:0]     frames_left_reg, frames_left_next;
    logic [COUNT_W-1:0] capture_start_reg, capture_start_next;
    logic [PCW-1:0]     cpre_reg, cpre_next;

    // stage logic
    logic               s1_go, s1_fire;
    logic               hit, trig, emit, last_c, from_mem;
    logic [PCW-1:0]     pre_eff, cpre_eff;
    logic [PSW-1:0]     post_eff;
    logic [FLW-1:0]     window_len, fl_cur;
    logic [COUNT_W-1:0] start_cur;
    logic [AW:0]        rd_sum, rd_wrap;
    logic [AW-1:0]      rd_addr;
    frame_t             mem_rd_data, out_frame;

    stpc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    stpc_detect u_detect (
        .cfg   (cfg),
        .frame (s1_frame_reg),
        .hit   (hit)
    );

    stpc_history #(
        .DEPTH (PRE_DEPTH),
        .AW    (AW)
    ) u_history (
        .clk     (clk),
        .wr_en   (s1_fire),
        .wr_addr (hist_wr_reg),
        .wr_data (s1_frame_reg),
        .rd_en   (s1_fire && emit && from_mem),
        .rd_addr (rd_addr),
        .rd_data (mem_rd_data)
    );

    // handshake: both stages move together when the result slot frees up
    assign s1_go    = !out_valid_reg || out_ready;
    assign s1_fire  = s1_valid_reg && s1_go;
    assign in_ready = !s1_valid_reg || s1_go;

    // clipped window lengths
    always_comb
    begin
        pre_eff  = (32'(cfg.pre_frames) > 32'(PRE_DEPTH)) ?
                   PCW'(PRE_DEPTH) : PCW'(cfg.pre_frames);
        post_eff = (32'(cfg.post_frames) > 32'(POST_MAX)) ?
                   PSW'(POST_MAX) : PSW'(cfg.post_frames);
        window_len = FLW'(pre_eff) + FLW'(post_eff);
    end

    // trigger decision and window bookkeeping for the frame in stage 1
    always_comb
    begin
        trig = (frames_left_reg == '0) && (primed_reg >= pre_eff) &&
               (window_len != '0) && hit;
        fl_cur    = trig ? window_len : frames_left_reg;
        cpre_eff  = trig ? pre_eff : cpre_reg;
        start_cur = trig ? (frame_count_reg - COUNT_W'(pre_eff)) : capture_start_reg;
        emit      = (fl_cur != '0);
        last_c    = (fl_cur == FLW'(1));
        from_mem  = (cpre_eff != '0);

        // delayed entry: write pointer minus the latched pretrigger depth
        rd_sum  = {1'b0, hist_wr_reg} + (AW+1)'(PRE_DEPTH - 32'(cpre_eff));
        rd_wrap = rd_sum - (AW+1)'(PRE_DEPTH);
        rd_addr = (rd_sum >= (AW+1)'(PRE_DEPTH)) ? rd_wrap[AW-1:0] : rd_sum[AW-1:0];

        frames_left_next   = frames_left_reg;
        capture_start_next = capture_start_reg;
        cpre_next          = cpre_reg;
        frame_count_next   = frame_count_reg;
        hist_wr_next       = hist_wr_reg;
        primed_next        = primed_reg;
        if (s1_fire)
        begin
            frames_left_next   = emit ? (fl_cur - FLW'(1)) : fl_cur;
            capture_start_next = start_cur;
            cpre_next          = cpre_eff;
            frame_count_next   = frame_count_reg + COUNT_W'(1);
            hist_wr_next       = (hist_wr_reg == AW'(PRE_DEPTH - 1)) ?
                                 '0 : hist_wr_reg + AW'(1);
            if (primed_reg != PCW'(PRE_DEPTH))
            begin
                primed_next = primed_reg + PCW'(1);
            end
        end

        s1_valid_next  = in_ready ? in_valid : s1_valid_reg;
        out_valid_next = s1_go ? (s1_valid_reg && emit) : out_valid_reg;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
            frame_count_reg   <= '0;
            hist_wr_reg       <= '0;
            primed_reg        <= '0;
            frames_left_reg   <= '0;
            capture_start_reg <= '0;
            cpre_reg          <= '0;
        end
        else
        begin
            s1_valid_reg      <= s1_valid_next;
            out_valid_reg     <= out_valid_next;
            frame_count_reg   <= frame_count_next;
            hist_wr_reg       <= hist_wr_next;
            primed_reg        <= primed_next;
            frames_left_reg   <= frames_left_next;
            capture_start_reg <= capture_start_next;
            cpre_reg          <= cpre_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_frame_reg <= {sample_ch3, sample_ch2, sample_ch1, sample_ch0};
        end
        if (s1_fire && emit)
        begin
            out_from_mem_reg <= from_mem;
            out_frame_reg    <= s1_frame_reg;
            out_start_reg    <= start_cur;
            out_last_reg     <= last_c;
        end
    end

    // result beat
    assign out_frame    = out_from_mem_reg ? mem_rd_data : out_frame_reg;
    assign out_valid    = out_valid_reg;
    assign out_ch0      = signed'(out_frame[0*SAMPLE_W +: SAMPLE_W]);
    assign out_ch1      = signed'(out_frame[1*SAMPLE_W +: SAMPLE_W]);
    assign out_ch2      = signed'(out_frame[2*SAMPLE_W +: SAMPLE_W]);
    assign out_ch3      = signed'(out_frame[3*SAMPLE_W +: SAMPLE_W]);
    assign window_start = out_start_reg;
    assign is_last      = out_last_reg;

    // the last beat of a window closes the capture
    `STPC_ASSERT_NEXT(a_last_closes, s1_fire && emit && last_c, frames_left_reg == '0)
    // a beat that leaves stage 1 with a result lands in the result slot
    `STPC_ASSERT_NEXT(a_emit_lands, s1_fire && emit, out_valid_reg)
    // the fill count saturates at the line depth
    `STPC_ASSERT_SAME(a_primed_sat, 1'b1, primed_reg <= PCW'(PRE_DEPTH))
    // no trigger while a capture is still running
    `STPC_ASSERT_SAME(a_no_retrigger, frames_left_reg != '0, cpre_eff == cpre_reg)

endmodule
